// ===== design/kvt_pkg.sv =====
package kvt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int ENTRY_W     = 2 * DATA_W;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_EXIST  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                     rejected;
		logic                     found;
		logic signed [DATA_W-1:0] read_value;
	} result_t;

endpackage

// ===== design/kvt_ram.sv =====
module kvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/kvt_ctrl.sv =====
module kvt_ctrl import kvt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// input item
	input  logic                     in_valid,
	output logic                     in_ready,
	input  cmd_t                     command,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] value,
	// table memory
	output logic                     mem_wr_en,
	output logic [IDX_W-1:0]         mem_wr_addr,
	output logic [ENTRY_W-1:0]       mem_wr_data,
	output logic                     mem_rd_en,
	output logic [IDX_W-1:0]         mem_rd_addr,
	input  logic [ENTRY_W-1:0]       mem_rd_data,
	// result hand-off to the output register
	input  logic                     out_free,
	output logic                     res_load,
	output result_t                  res
);

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         fill_q;
	logic [CNT_W-1:0]         rd_idx_q;
	cmd_t                     cmd_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     pend_s1;
	logic [IDX_W-1:0]         addr_s1;
	result_t                  res_q;

	logic accept;
	logic full;
	logic issue;
	logic hit;
	logic miss;

	assign accept = in_valid && in_ready;
	assign full   = (fill_q == CNT_W'(TABLE_DEPTH));
	assign issue  = (state_q == ST_SCAN) && (rd_idx_q < fill_q);
	assign hit    = (state_q == ST_SCAN) && pend_s1 && (mem_rd_data[DATA_W-1:0] == key_q);
	assign miss   = (state_q == ST_SCAN) && pend_s1 && !hit && !issue;
	assign res    = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_SET || fill_q == '0) begin
						state_d = ST_RESULT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit || miss) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory strobes and handshake
	always_comb begin
		in_ready    = 1'b0;
		res_load    = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = fill_q[IDX_W-1:0];
		mem_wr_data = {value, key};
		mem_rd_en   = 1'b0;
		mem_rd_addr = rd_idx_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				mem_wr_en = in_valid && (command == CMD_SET) && !full;
			end
			ST_SCAN: begin
				mem_rd_en = issue;
				if (hit && cmd_q == CMD_UPDATE) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = addr_s1;
					mem_wr_data = {value_q, key_q};
				end
			end
			ST_RESULT: begin
				res_load = out_free;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			// count appended entries
			if (accept && command == CMD_SET && !full) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		addr_s1 <= rd_idx_q[IDX_W-1:0];
		if (accept) begin
			cmd_q   <= command;
			key_q   <= key;
			value_q <= value;
			res_q   <= '{rejected: (command == CMD_SET) && full, found: 1'b0, read_value: '0};
		end else if (hit) begin
			res_q.found <= 1'b1;
			if (cmd_q == CMD_GET) begin
				res_q.read_value <= mem_rd_data[ENTRY_W-1:DATA_W];
			end
		end
	end

endmodule

// ===== design/key_value_table.sv =====
// Key-value table of up to 64 pairs of signed 32-bit keys and values, kept in
// insertion order in one synchronous memory. tuser selects the command: set
// appends a pair without a duplicate check (rejected when the table is full),
// get returns the value of the earliest matching key, update overwrites it, and
// exist reports a hit. Every transfer in gives exactly one transfer out. Get,
// update and exist read one entry per cycle through the single table read port
// and stop at the first match or after the last filled entry; on an empty table
// they skip the scan. A new item is taken as soon as the previous result has
// moved into the output register.
module key_value_table import kvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // key[31:0], value[63:32]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // read_value[31:0]
	output logic [1:0]  m_tuser   // found[0], rejected[1]
);

	logic               mem_wr_en;
	logic [IDX_W-1:0]   mem_wr_addr;
	logic [ENTRY_W-1:0] mem_wr_data;
	logic               mem_rd_en;
	logic [IDX_W-1:0]   mem_rd_addr;
	logic [ENTRY_W-1:0] mem_rd_data;
	logic               out_free;
	logic               res_load;
	result_t            res;

	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	kvt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	kvt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.command     (cmd_t'(s_tuser)),
		.key         (s_tdata[DATA_W-1:0]),
		.value       (s_tdata[ENTRY_W-1:DATA_W]),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.out_free    (out_free),
		.res_load    (res_load),
		.res         (res)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// output register: load a finished result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_tdata_q <= res.read_value;
			m_tuser_q <= {res.rejected, res.found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a result is never both a hit and a rejected set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("result flags found and rejected together");

	// a value is only returned on a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("nonzero read_value on a miss");

	// an update write-back never collides with the scan read
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
		else $error("table write and read at the same entry");

	// a result is only loaded when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending transfer");

endmodule
